### rtl/core/deadline_timer_queue_macros.svh
// Assertion macros shared by the timer queue RTL
`ifndef DEADLINE_TIMER_QUEUE_MACROS_SVH
`define DEADLINE_TIMER_QUEUE_MACROS_SVH

// Same-cycle implication, checked outside reset
`define DTQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define DTQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/dtq_pkg.sv
// Shared codes and constants of the deadline timer queue
package dtq_pkg;
    localparam int DEADLINE_BITS = 64;
    localparam int ORDER_BITS    = 32;
    localparam int MAX_RESULTS   = 32;
    localparam int REL_BITS      = $clog2(MAX_RESULTS + 1);

    typedef logic [1:0] t_func;
    typedef logic [2:0] t_status;

    localparam t_func FUNC_REGISTER = 2'd0;
    localparam t_func FUNC_CANCEL   = 2'd1;
    localparam t_func FUNC_TICK     = 2'd2;

    localparam t_status ST_ACCEPTED  = 3'd0;
    localparam t_status ST_FULL      = 3'd1;
    localparam t_status ST_NOT_FOUND = 3'd2;
    localparam t_status ST_RELEASED  = 3'd3;
    localparam t_status ST_NONE_DUE  = 3'd4;
endpackage

### rtl/core/dtq_store.sv
// Entry memory: one write port, one registered read port
module dtq_store #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 112
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // register read word
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/core/dtq_cmp.sv
// Shared ordering unit: does entry a leave before entry b
module dtq_cmp (
    input  logic [dtq_pkg::DEADLINE_BITS-1:0] i_a_dl,
    input  logic [dtq_pkg::ORDER_BITS-1:0]    i_a_ord,
    input  logic [dtq_pkg::DEADLINE_BITS-1:0] i_b_dl,
    input  logic [dtq_pkg::ORDER_BITS-1:0]    i_b_ord,
    output logic                              o_first
);
    import dtq_pkg::*;
    logic [ORDER_BITS-1:0] ord_diff;

    // earlier deadline wins; on a tie the older wrapped stamp wins
    assign ord_diff = i_a_ord - i_b_ord;
    assign o_first  = (i_a_dl != i_b_dl) ? (i_a_dl < i_b_dl) : ord_diff[ORDER_BITS-1];
endmodule

### rtl/core/deadline_timer_queue.sv
// Deadline timer queue: register, cancel and tick over a scanned entry memory.
// Register: result in the cycle after start, busy stays low.
// Cancel: busy through load, scan and decide, plus a drop if found; one result.
// Tick: a load, scan, decide and drop pass per released entry, then a closing
// scan unless the queue empties or the release cap is reached.
// Reset (synchronous) empties the queue and clears the stamp; the store is not cleared.
`include "deadline_timer_queue_macros.svh"
module deadline_timer_queue #(
    parameter int QUEUE_DEPTH = 32,
    parameter int HANDLE_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  dtq_pkg::t_func                    i_func,
    input  logic [HANDLE_BITS-1:0]            i_handle_id,
    input  logic [dtq_pkg::DEADLINE_BITS-1:0] i_deadline,
    input  logic [dtq_pkg::DEADLINE_BITS-1:0] i_now_time,
    output logic                              o_valid,
    output dtq_pkg::t_status                  o_status,
    output logic [HANDLE_BITS-1:0]            o_released_handle,
    output logic [dtq_pkg::DEADLINE_BITS-1:0] o_released_deadline,
    output logic                              o_last
);
    import dtq_pkg::*;

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = DEADLINE_BITS + ORDER_BITS + HANDLE_BITS;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOAD   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_DROP   = 3'd4;

    logic [2:0]               r_state, n_state;
    t_func                    r_func, n_func;
    logic [HANDLE_BITS-1:0]   r_hid, n_hid;
    logic [DEADLINE_BITS-1:0] r_now, n_now;
    logic [CW-1:0]            r_count, n_count;
    logic [ORDER_BITS-1:0]    r_seq, n_seq;
    logic [IW-1:0]            r_cidx, n_cidx;
    logic                     r_found, n_found;
    logic [DEADLINE_BITS-1:0] r_best_dl, n_best_dl;
    logic [HANDLE_BITS-1:0]   r_best_h, n_best_h;
    logic [ORDER_BITS-1:0]    r_best_ord, n_best_ord;
    logic [IW-1:0]            r_best_idx, n_best_idx;
    logic                     r_pend_v, n_pend_v;
    logic [HANDLE_BITS-1:0]   r_pend_h, n_pend_h;
    logic [DEADLINE_BITS-1:0] r_pend_dl, n_pend_dl;
    logic [REL_BITS-1:0]      r_nrel, n_nrel;
    logic                     r_o_valid, n_o_valid;
    t_status                  r_o_status, n_o_status;
    logic [HANDLE_BITS-1:0]   r_o_h, n_o_h;
    logic [DEADLINE_BITS-1:0] r_o_dl, n_o_dl;
    logic                     r_o_last, n_o_last;

    logic                     we;
    logic [IW-1:0]            waddr, raddr;
    logic [EW-1:0]            wdata, rdata;
    logic [DEADLINE_BITS-1:0] rd_dl;
    logic [ORDER_BITS-1:0]    rd_ord;
    logic [HANDLE_BITS-1:0]   rd_h;
    logic                     first;
    logic                     cand;
    logic [CW-1:0]            count_m1;

    dtq_store #(.DEPTH(QUEUE_DEPTH), .WIDTH(EW)) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign rd_h   = rdata[HANDLE_BITS-1:0];
    assign rd_ord = rdata[HANDLE_BITS+ORDER_BITS-1:HANDLE_BITS];
    assign rd_dl  = rdata[EW-1:HANDLE_BITS+ORDER_BITS];

    dtq_cmp u_cmp (
        .i_a_dl  (rd_dl),
        .i_a_ord (rd_ord),
        .i_b_dl  (r_best_dl),
        .i_b_ord (r_best_ord),
        .o_first (first)
    );

    assign count_m1 = r_count - CW'(1);
    assign cand     = (r_func == FUNC_CANCEL) ? (rd_h == r_hid) : 1'b1;

    // sequence each command through idle, load, scan, decide and drop
    always_comb begin
        n_state = r_state;   n_func = r_func;       n_hid = r_hid;
        n_now = r_now;       n_count = r_count;     n_seq = r_seq;
        n_cidx = r_cidx;     n_found = r_found;     n_best_dl = r_best_dl;
        n_best_h = r_best_h; n_best_ord = r_best_ord; n_best_idx = r_best_idx;
        n_pend_v = r_pend_v; n_pend_h = r_pend_h;   n_pend_dl = r_pend_dl;
        n_nrel = r_nrel;
        n_o_valid = 1'b0;    n_o_status = r_o_status; n_o_h = r_o_h;
        n_o_dl = r_o_dl;     n_o_last = r_o_last;
        we = 1'b0;
        waddr = r_count[IW-1:0];
        wdata = {i_deadline, r_seq, i_handle_id};
        raddr = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_func = i_func;
                    n_hid = i_handle_id;
                    n_now = i_now_time;
                    n_pend_v = 1'b0;
                    n_nrel = '0;
                    n_o_h = i_handle_id;
                    n_o_dl = i_deadline;
                    n_o_last = 1'b1;
                    case (i_func)
                        FUNC_REGISTER: begin
                            n_o_valid = 1'b1;
                            if (r_count == CW'(QUEUE_DEPTH)) begin
                                n_o_status = ST_FULL;
                            end else begin
                                n_o_status = ST_ACCEPTED;
                                we = 1'b1;
                                n_seq = r_seq + ORDER_BITS'(1);
                                n_count = r_count + CW'(1);
                            end
                        end
                        FUNC_CANCEL: begin
                            if (r_count == '0) begin
                                n_o_valid = 1'b1;
                                n_o_status = ST_NOT_FOUND;
                                n_o_dl = '0;
                            end else begin
                                n_state = S_LOAD;
                            end
                        end
                        FUNC_TICK: begin
                            if (r_count == '0) begin
                                n_o_valid = 1'b1;
                                n_o_status = ST_NONE_DUE;
                                n_o_h = '0;
                                n_o_dl = '0;
                            end else begin
                                n_state = S_LOAD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LOAD: begin
                // fetch slot zero and open a fresh search
                raddr = '0;
                n_cidx = '0;
                n_found = 1'b0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                // compare one slot a cycle against the best so far
                raddr = r_cidx + IW'(1);
                if (cand && (!r_found || first)) begin
                    n_found = 1'b1;
                    n_best_dl = rd_dl;
                    n_best_h = rd_h;
                    n_best_ord = rd_ord;
                    n_best_idx = r_cidx;
                end
                if (r_cidx == count_m1[IW-1:0]) begin
                    n_state = S_DECIDE;
                end else begin
                    n_cidx = r_cidx + IW'(1);
                end
            end
            S_DECIDE: begin
                // fetch the tail slot for the hole fill
                raddr = count_m1[IW-1:0];
                n_o_last = 1'b1;
                if (r_func == FUNC_CANCEL) begin
                    n_o_valid = 1'b1;
                    n_o_h = r_hid;
                    if (!r_found) begin
                        n_o_status = ST_NOT_FOUND;
                        n_o_dl = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_o_status = ST_ACCEPTED;
                        n_o_dl = r_best_dl;
                        n_state = S_DROP;
                    end
                end else if (!r_found || (r_best_dl > r_now)) begin
                    n_o_valid = 1'b1;
                    if (r_pend_v) begin
                        n_o_status = ST_RELEASED;
                        n_o_h = r_pend_h;
                        n_o_dl = r_pend_dl;
                    end else begin
                        n_o_status = ST_NONE_DUE;
                        n_o_h = '0;
                        n_o_dl = '0;
                    end
                    n_pend_v = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    // hold this release until the next one shows if it was last
                    if (r_pend_v) begin
                        n_o_valid = 1'b1;
                        n_o_status = ST_RELEASED;
                        n_o_h = r_pend_h;
                        n_o_dl = r_pend_dl;
                        n_o_last = 1'b0;
                    end
                    n_pend_v = 1'b1;
                    n_pend_h = r_best_h;
                    n_pend_dl = r_best_dl;
                    n_nrel = r_nrel + REL_BITS'(1);
                    n_state = S_DROP;
                end
            end
            S_DROP: begin
                // move the tail entry into the hole
                we = 1'b1;
                waddr = r_best_idx;
                wdata = rdata;
                n_count = count_m1;
                if (r_func == FUNC_CANCEL) begin
                    n_state = S_IDLE;
                end else if (count_m1 == '0 || r_nrel == REL_BITS'(MAX_RESULTS)) begin
                    n_o_valid = 1'b1;
                    n_o_status = ST_RELEASED;
                    n_o_h = r_pend_h;
                    n_o_dl = r_pend_dl;
                    n_o_last = 1'b1;
                    n_pend_v = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_seq <= '0;
            r_pend_v <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_seq <= n_seq;
            r_pend_v <= n_pend_v;
            r_o_valid <= n_o_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_func <= n_func;       r_hid <= n_hid;         r_now <= n_now;
        r_cidx <= n_cidx;       r_found <= n_found;     r_best_dl <= n_best_dl;
        r_best_h <= n_best_h;   r_best_ord <= n_best_ord; r_best_idx <= n_best_idx;
        r_pend_h <= n_pend_h;   r_pend_dl <= n_pend_dl; r_nrel <= n_nrel;
        r_o_status <= n_o_status; r_o_h <= n_o_h;       r_o_dl <= n_o_dl;
        r_o_last <= n_o_last;
    end

    assign busy                = (r_state != S_IDLE);
    assign o_valid             = r_o_valid;
    assign o_status            = r_o_status;
    assign o_released_handle   = r_o_h;
    assign o_released_deadline = r_o_dl;
    assign o_last              = r_o_last;

    `DTQ_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CW'(QUEUE_DEPTH), "entry count beyond depth")
    `DTQ_ASSERT_NXT(a_reg_reply, start && !busy && i_func == FUNC_REGISTER, o_valid && o_last, "register gave no reply")
    `DTQ_ASSERT_IMP(a_single_last, o_valid && o_status != ST_RELEASED, o_last, "single word not marked last")
    `DTQ_ASSERT_IMP(a_idle_pend, r_state == S_IDLE, !r_pend_v, "release left pending while idle")
endmodule

### tb/sv/tb_deadline_timer_queue.sv
// Self-checking testbench of the deadline timer queue
module tb_deadline_timer_queue;
    import dtq_pkg::*;

    localparam int QDEPTH   = 32;
    localparam int HBITS    = 16;
    localparam int N_RANDOM = 160;

    typedef struct packed {
        t_status     status;
        logic [15:0] handle;
        logic [63:0] deadline;
        logic        last;
    } t_word;

    typedef struct {
        t_func       func;
        logic [15:0] handle;
        logic [63:0] deadline;
        logic [63:0] now;
        logic        fixed;
        t_status     status;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_func       i_func = FUNC_REGISTER;
    logic [15:0] i_handle_id = '0;
    logic [63:0] i_deadline = '0;
    logic [63:0] i_now_time = '0;
    logic        o_valid;
    t_status     o_status;
    logic [15:0] o_released_handle;
    logic [63:0] o_released_deadline;
    logic        o_last;

    // model copy of the queue
    logic [63:0] tq_deadline [QDEPTH];
    logic [15:0] tq_handle [QDEPTH];
    logic [31:0] tq_stamp [QDEPTH];
    int          tq_count;
    logic [31:0] next_stamp;

    t_word       due_words [$];
    int          mismatches;
    int          sender_idle_pct;
    logic        next_fixed;
    t_status     next_status;

    deadline_timer_queue #(.QUEUE_DEPTH(QDEPTH), .HANDLE_BITS(HBITS)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_func(i_func), .i_handle_id(i_handle_id), .i_deadline(i_deadline),
        .i_now_time(i_now_time), .o_valid(o_valid), .o_status(o_status),
        .o_released_handle(o_released_handle),
        .o_released_deadline(o_released_deadline), .o_last(o_last)
    );

    always #4 i_clk = ~i_clk;

    // true when slot a leaves before slot b
    function automatic logic leaves_first(int a, int b);
        logic [31:0] diff;
        diff = tq_stamp[a] - tq_stamp[b];
        if (tq_deadline[a] != tq_deadline[b]) return tq_deadline[a] < tq_deadline[b];
        return diff[31];
    endfunction

    function automatic void remove_slot(int s);
        tq_deadline[s] = tq_deadline[tq_count-1];
        tq_handle[s]   = tq_handle[tq_count-1];
        tq_stamp[s]    = tq_stamp[tq_count-1];
        tq_count--;
    endfunction

    // work out the words one command causes and queue them
    function automatic void predict_words(t_func f, logic [15:0] h, logic [63:0] dl,
                                          logic [63:0] now);
        int    best;
        int    n;
        logic  found;
        t_word w;
        found = 1'b0;
        best = 0;
        n = 0;
        case (f)
            FUNC_REGISTER: begin
                if (tq_count >= QDEPTH) begin
                    due_words.push_back('{ST_FULL, h, dl, 1'b1});
                end else begin
                    tq_deadline[tq_count] = dl;
                    tq_handle[tq_count] = h;
                    tq_stamp[tq_count] = next_stamp;
                    next_stamp++;
                    tq_count++;
                    due_words.push_back('{ST_ACCEPTED, h, dl, 1'b1});
                end
            end
            FUNC_CANCEL: begin
                for (int i = 0; i < tq_count; i++)
                    if (tq_handle[i] == h && (!found || leaves_first(i, best))) begin
                        best = i;
                        found = 1'b1;
                    end
                if (!found) begin
                    due_words.push_back('{ST_NOT_FOUND, h, 64'd0, 1'b1});
                end else begin
                    due_words.push_back('{ST_ACCEPTED, h, tq_deadline[best], 1'b1});
                    remove_slot(best);
                end
            end
            FUNC_TICK: begin
                while (tq_count > 0 && n < MAX_RESULTS) begin
                    best = 0;
                    for (int i = 1; i < tq_count; i++)
                        if (leaves_first(i, best)) best = i;
                    if (tq_deadline[best] > now) break;
                    due_words.push_back('{ST_RELEASED, tq_handle[best], tq_deadline[best],
                                          1'b0});
                    remove_slot(best);
                    n++;
                end
                if (n == 0) begin
                    due_words.push_back('{ST_NONE_DUE, 16'd0, 64'd0, 1'b1});
                end else begin
                    w = due_words.pop_back();
                    w.last = 1'b1;
                    due_words.push_back(w);
                end
            end
            default: ;
        endcase
    endfunction

    // compare each word leaving the block with the oldest expectation
    always @(posedge i_clk) begin
        t_word w;
        if (i_rst_n && o_valid) begin
            if (due_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word status=%0d", o_status);
            end else begin
                w = due_words.pop_front();
                if (w.status != o_status || w.handle != o_released_handle ||
                    w.deadline != o_released_deadline || w.last != o_last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %0d/%h/%h/%0d got %0d/%h/%h/%0d",
                                 w.status, w.handle, w.deadline, w.last, o_status,
                                 o_released_handle, o_released_deadline, o_last);
                end else if (next_fixed && w.last && w.status != next_status) begin
                    mismatches++;
                end
            end
        end
    end

    // drive one command and wait for its acceptance; start stays high for the next one
    task automatic send_cmd(t_func f, logic [15:0] h, logic [63:0] dl, logic [63:0] now);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_func <= f;
        i_handle_id <= h;
        i_deadline <= dl;
        i_now_time <= now;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_words(f, h, dl, now);
    endtask

    // drop start and wait until every expected word has come
    task automatic drain_words();
        start <= 1'b0;
        while (due_words.size() != 0) @(posedge i_clk);
        repeat (QDEPTH * 40) @(posedge i_clk);
    endtask

    function automatic logic [63:0] pick_time();
        case ($urandom_range(3))
            0: return {$urandom, $urandom};
            1: return 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(3);
            default: return 64'd1000 + $urandom_range(200);
        endcase
    endfunction

    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        t_row  rows [$];
        t_func f;
        int    pick;
        mismatches = 0;
        tq_count = 0;
        next_stamp = '0;
        next_fixed = 1'b0;
        next_status = ST_ACCEPTED;
        sender_idle_pct = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table: fixed status only where it is plain
        rows.push_back('{FUNC_TICK, 16'h0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_NONE_DUE});
        rows.push_back('{FUNC_CANCEL, 16'hFFFF, 64'h0, 64'h0, 1'b1, ST_NOT_FOUND});
        rows.push_back('{FUNC_REGISTER, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b1,
                         ST_ACCEPTED});
        rows.push_back('{FUNC_REGISTER, 16'h0000, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
                         ST_ACCEPTED});
        rows.push_back('{FUNC_REGISTER, 16'h00A5, 64'h5, 64'h0, 1'b0, ST_ACCEPTED});
        rows.push_back('{FUNC_REGISTER, 16'h00A5, 64'h5, 64'h0, 1'b0, ST_ACCEPTED});
        rows.push_back('{FUNC_REGISTER, 16'h5A5A, 64'h5, 64'h0, 1'b0, ST_ACCEPTED});
        rows.push_back('{FUNC_CANCEL, 16'h00A5, 64'h0, 64'h0, 1'b0, ST_ACCEPTED});
        rows.push_back('{t_func'(3), 16'h1234, 64'h9, 64'h9, 1'b0, ST_ACCEPTED});
        rows.push_back('{FUNC_TICK, 16'h0, 64'h0, 64'h4, 1'b0, ST_ACCEPTED});
        rows.push_back('{FUNC_TICK, 16'h0, 64'h0, 64'h5, 1'b0, ST_ACCEPTED});
        rows.push_back('{FUNC_TICK, 16'h0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0,
                         ST_ACCEPTED});
        rows.push_back('{FUNC_TICK, 16'h0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0,
                         ST_ACCEPTED});
        rows.push_back('{FUNC_TICK, 16'h0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
                         ST_NONE_DUE});
        foreach (rows[i]) begin
            next_fixed = rows[i].fixed;
            next_status = rows[i].status;
            send_cmd(rows[i].func, rows[i].handle, rows[i].deadline, rows[i].now);
            drain_words();
        end
        next_fixed = 1'b0;

        // fill past full, release all due with the result cap, then cancel one handle
        for (int i = 0; i < QDEPTH + 2; i++)
            send_cmd(FUNC_REGISTER, 16'(i % 5), 64'(i % 3), 64'h0);
        send_cmd(FUNC_TICK, 16'h0, 64'h0, 64'h2);
        send_cmd(FUNC_CANCEL, 16'h3, 64'h0, 64'h0);
        drain_words();

        // random part in three idling phases
        for (int ph = 0; ph < 3; ph++) begin
            sender_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 80 : 0;
            for (int k = 0; k < N_RANDOM / 3; k++) begin
                pick = $urandom_range(99);
                if (pick < 50) f = FUNC_REGISTER;
                else if (pick < 72) f = FUNC_CANCEL;
                else if (pick < 97) f = FUNC_TICK;
                else f = t_func'(3);
                send_cmd(f, ($urandom_range(1)) ? 16'($urandom_range(7)) : 16'($urandom),
                         pick_time(), pick_time());
                if (k == 20) drain_words();
            end
            drain_words();
        end

        if (mismatches == 0 && due_words.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
